// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_SPACES = 4;
  localparam int NCELLS     = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(NCELLS);
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int TAB_W  = $clog2(TAB_SPACES + 1);
  localparam int CELL_W = 16;

  localparam logic       OP_PUT       = 1'b0;
  localparam logic       OP_READ      = 1'b1;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  typedef struct packed {
    logic        op;
    logic [7:0]  char_code;
    logic [3:0]  fg_color;
    logic [3:0]  bg_color;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
  } out_item_t;

endpackage

// ===== rtl/tcw_ram.sv =====
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/text_console_writer.sv =====
// Text console writer: a COLUMNS x ROWS screen of 16-bit cells (attribute byte
// high, character byte low) held in one synchronous RAM, plus a cursor. An item
// is taken when start is high and busy is low; its single result appears on
// out_item for exactly one cycle with out_valid high, and the receiver cannot
// hold it off. A backspace item answers in the cycle after it is taken. A read
// answers after S_READ and an ordinary character after its RAM write in
// S_GLYPH; a tab writes its spaces in S_GLYPH, one per cell, before it answers.
// busy is low only in S_IDLE, so a new item is taken only once the last is done.
// A newline on the bottom row, or a character that wraps there, scrolls the
// screen through the single RAM port pair: one cell copy per cycle through the
// upper rows, then the bottom row is filled. After reset the block is busy
// while it clears the screen to zero.
module text_console_writer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tcw_pkg::in_item_t  in_item,
  output logic               out_valid,
  output tcw_pkg::out_item_t out_item
);

  import tcw_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_GLYPH  = 3'd3;
  localparam logic [2:0] S_NL     = 3'd4;
  localparam logic [2:0] S_SCROLL = 3'd5;
  localparam logic [2:0] S_FILL   = 3'd6;

  localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(NCELLS - 1);
  localparam logic [ADDR_W-1:0] SCROLL_END  = ADDR_W'(NCELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  COL_LIMIT   = COL_W'(COLUMNS);
  localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] sc_r, sc_nxt;        // clear, scroll and fill pointer
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [TAB_W-1:0]  cnt_r, cnt_nxt;      // characters left in this item
  logic [7:0]        ch_r, ch_nxt;
  logic [7:0]        attr_r, attr_nxt;
  logic              ret_glyph_r, ret_glyph_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_data_r, out_data_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (NCELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    sc_nxt        = sc_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    cnt_nxt       = cnt_r;
    ch_nxt        = ch_r;
    attr_nxt      = attr_r;
    ret_glyph_nxt = ret_glyph_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    unique case (state_r)
      S_CLEAR: begin
        // Sweep the whole screen to zero after reset.
        ram_we    = 1'b1;
        ram_waddr = sc_r;
        if (sc_r == LAST_CELL) begin
          sc_nxt    = '0;
          state_nxt = S_IDLE;
        end else begin
          sc_nxt = sc_r + ADDR_W'(1);
        end
      end

      S_IDLE: begin
        ram_raddr = ADDR_W'(in_item.cell_index);
        if (start) begin
          attr_nxt = {in_item.bg_color, in_item.fg_color};
          ch_nxt   = in_item.char_code;
          if (in_item.op == OP_READ) begin
            // Cells beyond the screen read as zero without touching the RAM.
            rd_ok_nxt = ({21'd0, in_item.cell_index} < 32'(NCELLS));
            ram_re    = rd_ok_nxt;
            state_nxt = S_READ;
          end else begin
            unique case (in_item.char_code)
              CH_NEWLINE: begin
                state_nxt = S_NL;
              end
              CH_BACKSPACE: begin
                // Backspace never erases; at the origin it stays put.
                if (col_r == '0) begin
                  if (row_r != '0) begin
                    row_nxt = row_r - ROW_W'(1);
                    col_nxt = COL_LAST;
                  end
                end else begin
                  col_nxt = col_r - COL_W'(1);
                end
                out_data_nxt  = '0;
                out_valid_nxt = 1'b1;
              end
              CH_TAB: begin
                ch_nxt    = CH_SPACE;
                cnt_nxt   = TAB_W'(TAB_SPACES);
                state_nxt = S_GLYPH;
              end
              default: begin
                cnt_nxt   = TAB_W'(1);
                state_nxt = S_GLYPH;
              end
            endcase
          end
        end
      end

      S_READ: begin
        out_data_nxt  = rd_ok_r ? ram_rdata : 16'h0000;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_GLYPH: begin
        if (col_r >= COL_LIMIT) begin
          // Pending wrap: take the line feed first (scrolling on the bottom row), then write.
          col_nxt = '0;
          if (row_r < ROW_LAST) begin
            row_nxt = row_r + ROW_W'(1);
          end else begin
            ret_glyph_nxt = 1'b1;
            sc_nxt        = '0;
            state_nxt     = S_SCROLL;
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(row_r) * ROW_STRIDE + ADDR_W'(col_r);
          ram_wdata = {attr_r, ch_r};
          col_nxt   = col_r + COL_W'(1);
          cnt_nxt   = cnt_r - TAB_W'(1);
          if (cnt_r == TAB_W'(1)) begin
            out_data_nxt  = '0;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      S_NL: begin
        col_nxt = '0;
        if (row_r < ROW_LAST) begin
          row_nxt       = row_r + ROW_W'(1);
          out_data_nxt  = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ret_glyph_nxt = 1'b0;
          sc_nxt        = '0;
          state_nxt     = S_SCROLL;
        end
      end

      S_SCROLL: begin
        // Read one row ahead and write the previous read back one row up.
        // The write always trails the read, so the two never meet.
        if (sc_r != SCROLL_END) begin
          ram_re    = 1'b1;
          ram_raddr = sc_r + ROW_STRIDE;
        end
        if (sc_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = sc_r - ADDR_W'(1);
          ram_wdata = ram_rdata;
        end
        if (sc_r == SCROLL_END) begin
          state_nxt = S_FILL;
        end else begin
          sc_nxt = sc_r + ADDR_W'(1);
        end
      end

      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = sc_r;
        ram_wdata = {attr_r, 8'h00};
        if (sc_r == LAST_CELL) begin
          sc_nxt = '0;
          if (ret_glyph_r) begin
            state_nxt = S_GLYPH;
          end else begin
            out_data_nxt  = '0;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          sc_nxt = sc_r + ADDR_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sc_r        <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sc_r        <= sc_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    ch_r        <= ch_nxt;
    attr_r      <= attr_nxt;
    ret_glyph_r <= ret_glyph_nxt;
    rd_ok_r     <= rd_ok_nxt;
    out_data_r  <= out_data_nxt;
  end

  // The cursor registers settle at the same edge that raises the strobe and
  // stay put until the next item is taken.
  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_item.cell_data  = out_data_r;
  assign out_item.cursor_col = 7'(col_r);
  assign out_item.cursor_row = 5'(row_r);

endmodule

// ===== sim/text_console_writer_test.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the text console writer.
module text_console_writer_test;
  import tcw_pkg::*;

  // One planned input item, the idle cycles the sender spends before it, and
  // whether the sender first waits for every outstanding result to come back.
  typedef struct {
    in_item_t    item;
    int unsigned gap;
    bit          drain;
  } planned_item_t;

  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned MAX_GAP      = 18;
  localparam int unsigned TAIL_CYCLES  = 2200;  // longer than a full scroll
  localparam int unsigned REPORT_LIMIT = 10;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  text_console_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // Items still to be sent, and the console answers still to be seen.
  planned_item_t planned_items[$];
  out_item_t     expected_answers[$];

  // Shadow copy of the console: every cell, and the cursor. The column can sit
  // one past the last column while a wrap is pending.
  logic [CELL_W-1:0] shadow_screen [NCELLS];
  int unsigned       shadow_col;
  int unsigned       shadow_row;

  // Knobs read by the planner while it fills the item queue.
  bit quiet_stretch = 1'b0;  // plan no idle cycles for the current stretch
  bit drain_next    = 1'b0;  // the next planned item waits for a drained console

  int unsigned gap_left       = 0;
  int unsigned items_taken    = 0;
  int unsigned reads_taken    = 0;
  int unsigned scroll_count   = 0;
  int unsigned wrap_count     = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;

  // Move to column zero of the next row. On the bottom row the whole screen
  // moves up one row and the bottom row is refilled with the attribute and a
  // zero character.
  function automatic void shadow_line_feed(input logic [7:0] attr);
    shadow_col = 0;
    if (shadow_row < ROWS - 1) begin
      shadow_row++;
    end else begin
      scroll_count++;
      for (int i = 0; i < NCELLS - COLUMNS; i++)
        shadow_screen[i] = shadow_screen[i + COLUMNS];
      for (int c = 0; c < COLUMNS; c++)
        shadow_screen[NCELLS - COLUMNS + c] = {attr, 8'h00};
    end
  endfunction

  // Write one glyph at the cursor. A pending wrap is resolved first, so the
  // glyph lands at the start of the next row, which may scroll the screen.
  function automatic void shadow_put_glyph(input logic [7:0] glyph, input logic [7:0] attr);
    if (shadow_col >= COLUMNS) begin
      wrap_count++;
      shadow_line_feed(attr);
    end
    if (shadow_col < COLUMNS && shadow_row < ROWS)
      shadow_screen[shadow_row * COLUMNS + shadow_col] = {attr, glyph};
    shadow_col++;
  endfunction

  // Apply one accepted item to the shadow console and return the answer the
  // block must give for it.
  function automatic out_item_t apply_console_item(input in_item_t it);
    out_item_t  answer;
    logic [7:0] attr;
    attr = {it.bg_color, it.fg_color};
    answer.cell_data = '0;
    items_taken++;
    if (it.op == OP_READ) begin
      reads_taken++;
      if (it.cell_index < NCELLS)
        answer.cell_data = shadow_screen[it.cell_index];
    end else if (it.char_code == CH_NEWLINE) begin
      shadow_line_feed(attr);
    end else if (it.char_code == CH_BACKSPACE) begin
      // Backspace walks back across the row boundary but never past the origin.
      if (shadow_col == 0) begin
        if (shadow_row != 0) begin
          shadow_row--;
          shadow_col = COLUMNS - 1;
        end
      end else begin
        shadow_col--;
      end
    end else if (it.char_code == CH_TAB) begin
      for (int k = 0; k < TAB_SPACES; k++)
        shadow_put_glyph(CH_SPACE, attr);
    end else begin
      shadow_put_glyph(it.char_code, attr);
    end
    answer.cursor_col = shadow_col[6:0];
    answer.cursor_row = shadow_row[4:0];
    return answer;
  endfunction

  // Append one item to the plan, drawing its lead-in gap from the current
  // stretch and taking over a pending drain request.
  function automatic void plan_item(input logic op, input logic [7:0] glyph,
                                    input logic [3:0] fg, input logic [3:0] bg,
                                    input logic [10:0] index);
    planned_item_t p;
    p.item.op         = op;
    p.item.char_code  = glyph;
    p.item.fg_color   = fg;
    p.item.bg_color   = bg;
    p.item.cell_index = index;
    p.gap             = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
    p.drain           = drain_next;
    drain_next        = 1'b0;
    planned_items.push_back(p);
  endfunction

  // Sender. An item is taken at an edge where start is high and busy is low.
  // Its answer is predicted right there, then the sender either sits out the
  // next item's gap, holds off for a drain, or raises the next item at once so
  // that start stays high across back-to-back items.
  always @(posedge clk) begin
    bit free;
    if (!rst_n) begin
      start      <= 1'b0;
      gap_left   = 0;
      shadow_col = 0;
      shadow_row = 0;
      foreach (shadow_screen[i]) shadow_screen[i] = '0;
    end else begin
      free = !start;
      if (start && !busy) begin
        expected_answers.push_back(apply_console_item(in_item));
        free = 1'b1;
        if (planned_items.size() != 0) gap_left = planned_items[0].gap;
      end
      if (free) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (planned_items.size() != 0 &&
                     !(planned_items[0].drain && expected_answers.size() != 0)) begin
          in_item <= planned_items[0].item;
          start   <= 1'b1;
          void'(planned_items.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Receiver. The block cannot be stalled, so every strobe is one answer that
  // must match the oldest expectation field by field.
  always @(posedge clk) begin
    out_item_t want;
    if (out_valid === 1'b1) begin
      results_seen++;
      if (expected_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: unexpected answer: data %h col %0d row %0d", $realtime,
                   out_item.cell_data, out_item.cursor_col, out_item.cursor_row);
      end else begin
        want = expected_answers.pop_front();
        if (out_item.cell_data !== want.cell_data ||
            out_item.cursor_col !== want.cursor_col ||
            out_item.cursor_row !== want.cursor_row) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: mismatch: expected data %h col %0d row %0d, got data %h col %0d row %0d",
                     $realtime, want.cell_data, want.cursor_col, want.cursor_row,
                     out_item.cell_data, out_item.cursor_col, out_item.cursor_row);
        end
      end
    end
  end

  // Plan the whole run, release reset, then wait for the console to go quiet.
  initial begin
    int unsigned base;
    int unsigned seg;
    int unsigned len;
    int unsigned pick;
    logic [3:0]  fg;
    logic [3:0]  bg;
    logic [7:0]  glyph;
    logic [10:0] index;

    // Directed opening. The screen is fresh, so the first reads hit cleared
    // cells at both corners, the first index past the screen and the top of
    // the index range.
    plan_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd0);
    plan_item(OP_READ, 8'hFF, 4'hF, 4'hF, 11'd1999);
    plan_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd2000);
    plan_item(OP_READ, 8'hFF, 4'hF, 4'hF, 11'd2047);
    // Backspace at the origin must leave the cursor where it is.
    plan_item(OP_PUT, CH_BACKSPACE, 4'hF, 4'hF, 11'd2047);
    // Extreme character bytes and attribute nibbles, then a tab, read back.
    plan_item(OP_PUT, 8'hFF, 4'hF, 4'h0, 11'd0);
    plan_item(OP_PUT, 8'h00, 4'h0, 4'hF, 11'd2047);
    plan_item(OP_PUT, CH_TAB, 4'h5, 4'hA, 11'd0);
    plan_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd0);
    plan_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd1);
    plan_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd5);
    // Backspace inside a row, a newline, then backspace from column zero back
    // to the last column of the row above.
    plan_item(OP_PUT, CH_BACKSPACE, 4'h1, 4'h2, 11'd0);
    plan_item(OP_PUT, CH_NEWLINE, 4'h3, 4'hC, 11'd0);
    plan_item(OP_PUT, CH_BACKSPACE, 4'h1, 4'h2, 11'd0);
    // Filling the last column leaves a pending wrap. Backspace cancels it,
    // the next glyph re-arms it, and a tab then wraps before its spaces.
    plan_item(OP_PUT, 8'h41, 4'h7, 4'h1, 11'd0);
    plan_item(OP_PUT, CH_BACKSPACE, 4'h1, 4'h2, 11'd0);
    plan_item(OP_PUT, 8'h42, 4'h9, 4'h6, 11'd0);
    plan_item(OP_PUT, CH_TAB, 4'hE, 4'h3, 11'd0);
    // Same again with an ordinary glyph doing the wrap.
    plan_item(OP_PUT, CH_NEWLINE, 4'h2, 4'h4, 11'd0);
    plan_item(OP_PUT, CH_BACKSPACE, 4'h1, 4'h2, 11'd0);
    plan_item(OP_PUT, 8'h44, 4'hB, 4'h8, 11'd0);
    plan_item(OP_PUT, 8'h45, 4'hC, 4'h5, 11'd0);
    plan_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd79);
    plan_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd80);
    plan_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd159);
    plan_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd160);

    // Random part, built from stretches that look like console traffic: text
    // lines of up to 100 items (long ones wrap, and once the cursor reaches the
    // bottom every line scrolls), read bursts aimed mostly at the bottom rows
    // where scrolled content lands, short edits, runs of newlines, and noise.
    // The sender drains the console before the first stretch and now and then
    // after that.
    drain_next = 1'b1;
    base = planned_items.size();
    while (planned_items.size() - base < RANDOM_ITEMS) begin
      seg           = $urandom_range(0, 99);
      quiet_stretch = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 29) == 0) drain_next = 1'b1;
      fg = 4'($urandom_range(0, 15));
      bg = 4'($urandom_range(0, 15));
      if (seg < 45) begin
        len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 100);
        for (int k = 0; k < len; k++) begin
          pick  = $urandom_range(0, 19);
          glyph = (pick == 0) ? CH_TAB :
                  (pick == 1) ? CH_BACKSPACE : 8'($urandom_range(0, 255));
          plan_item(OP_PUT, glyph, fg, bg, 11'($urandom_range(0, 2047)));
        end
        if ($urandom_range(0, 4) != 0)
          plan_item(OP_PUT, CH_NEWLINE, fg, bg, 11'($urandom_range(0, 2047)));
      end else if (seg < 70) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          pick  = $urandom_range(0, 9);
          index = (pick < 5) ? 11'($urandom_range(NCELLS - 5 * COLUMNS, NCELLS - 1)) :
                  (pick < 8) ? 11'($urandom_range(0, NCELLS - 1)) :
                               11'($urandom_range(0, 2047));
          plan_item(OP_READ, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                    4'($urandom_range(0, 15)), index);
        end
      end else if (seg < 85) begin
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++)
          plan_item(OP_PUT, CH_BACKSPACE, fg, bg, 11'($urandom_range(0, 2047)));
        len = $urandom_range(0, 5);
        for (int k = 0; k < len; k++)
          plan_item(OP_PUT, 8'($urandom_range(0, 255)), fg, bg, 11'($urandom_range(0, 2047)));
      end else if (seg < 95) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
          plan_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    11'($urandom_range(0, 2047)));
      end else begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++)
          plan_item(OP_PUT, CH_NEWLINE, fg, bg, 11'($urandom_range(0, 2047)));
      end
    end

    // Reset is held from the start of the run and then released. The block then clears its screen on its
    // own, which the sender rides out by watching busy.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge so the queues and start have settled.
    while (planned_items.size() != 0 || start || expected_answers.size() != 0)
      @(negedge clk);
    // Give a stray answer time to show up, even one delayed by a full scroll.
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatch_count += expected_answers.size();

    $display("Sent %0d items (%0d cell reads) and checked %0d answers, %0d failing.",
             items_taken, reads_taken, results_seen, mismatch_count);
    $display("The screen scrolled %0d times and the cursor wrapped %0d times.",
             scroll_count, wrap_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run: every item scrolling the
  // screen after the longest sender gap, plus the clearing pass after reset.
  initial begin
    #200_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/text_console_writer.sv
sim/text_console_writer_test.sv
